>>> rtl/sdr_pkg.sv
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared types and constants of the SD card SPI single-block read block.
// ----------------------------------------------------------------------------
package sdr_pkg;

   localparam int BLOCK_BYTES = 512;
   localparam int DATA_CNT_W  = 10;
   localparam int WAIT_W      = 16;
   localparam int CRC_W       = 7;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int FRAME_BYTES = 6;
   localparam int FRAME_CNT_W = 3;

   localparam logic [7:0] CMD17_BYTE = 8'h51;
   localparam logic [7:0] DATA_TOKEN = 8'hFE;

   localparam logic [WAIT_W-1:0] R1_LIMIT_RESET = 16'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CRC_BYTE      = 1'b0,
      CSR_R1_WAIT_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_R1_ERR    = 2'd1,
      ST_TOKEN_ERR = 2'd2,
      ST_TOKEN_TMO = 2'd3
   } status_type;

   localparam logic KIND_TX = 1'b0;
   localparam logic KIND_RX = 1'b1;

   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
      logic       done_res;
      logic [1:0] status;
   } res_type;

   typedef struct packed {
      logic    load_frame;
      logic    load_single;
      res_type res;
   } ctl_type;

endpackage

>>> rtl/sdr_req_if.sv
// ----------------------------------------------------------------------------
// sdr_req_if
// Request channel: start of a read or a byte received from the card.
// ----------------------------------------------------------------------------
interface sdr_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] block_address;
   logic [15:0] token_wait_limit;
   logic [7:0]  received_byte;

   modport source (output valid, output operation, output block_address,
                   output token_wait_limit, output received_byte, input ready);
   modport sink   (input valid, input operation, input block_address,
                   input token_wait_limit, input received_byte, output ready);
endinterface

>>> rtl/sdr_rsp_if.sv
// ----------------------------------------------------------------------------
// sdr_rsp_if
// Response channel: command bytes to send and data bytes read.
// ----------------------------------------------------------------------------
interface sdr_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] byte_value;
   logic       done_res;
   logic [1:0] status;

   modport source (output valid, output kind, output byte_value,
                   output done_res, output status, input ready);
   modport sink   (input valid, input kind, input byte_value,
                   input done_res, input status, output ready);
endinterface

>>> rtl/sdr_ctrl.sv
// ----------------------------------------------------------------------------
// sdr_ctrl
// Read sequencer: R1 wait, data token wait and data byte count.
// ----------------------------------------------------------------------------
module sdr_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   sdr_req_if.sink                        req,
   input  logic                           out_free,
   input  logic [sdr_pkg::WAIT_W-1:0]     r1_wait_limit,
   output sdr_pkg::ctl_type               ctl
);
   import sdr_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_R1,
      PH_TOKEN,
      PH_DATA
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [WAIT_W-1:0]     wait_count_ff, wait_count_in;
   logic [WAIT_W-1:0]     token_limit_ff, token_limit_in;
   logic [DATA_CNT_W-1:0] data_count_ff, data_count_in;

   logic              accept;
   logic [7:0]        rx;
   logic [WAIT_W-1:0] wait_inc;
   logic [WAIT_W-1:0] r1_lim;
   logic              finish;
   status_type        fin_status;

   assign req.ready = out_free;
   assign accept    = req.valid && out_free;
   assign rx        = req.received_byte;
   assign wait_inc  = wait_count_ff + WAIT_W'(1);
   assign r1_lim    = (r1_wait_limit == '0) ? WAIT_W'(1) : r1_wait_limit;

   always_comb begin
      phase_in       = phase_ff;
      wait_count_in  = wait_count_ff;
      token_limit_in = token_limit_ff;
      data_count_in  = data_count_ff;
      finish         = 1'b0;
      fin_status     = ST_OK;
      ctl            = '0;
      if (accept) begin
         if (req.operation == OP_START) begin
            phase_in       = PH_R1;
            wait_count_in  = '0;
            token_limit_in = req.token_wait_limit;
            data_count_in  = '0;
            ctl.load_frame = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_R1: begin
                  if (!rx[7]) begin
                     if (rx[7:1] != '0) begin
                        finish     = 1'b1;
                        fin_status = ST_R1_ERR;
                     end else if (token_limit_ff == '0) begin
                        finish     = 1'b1;
                        fin_status = ST_TOKEN_TMO;
                     end else begin
                        phase_in      = PH_TOKEN;
                        wait_count_in = '0;
                     end
                  end else begin
                     wait_count_in = wait_inc;
                     if (wait_inc == '0 || wait_inc >= r1_lim) begin
                        finish     = 1'b1;
                        fin_status = ST_R1_ERR;
                     end
                  end
               end
               PH_TOKEN: begin
                  if (rx[7:5] == '0) begin
                     finish     = 1'b1;
                     fin_status = ST_TOKEN_ERR;
                  end else if (rx == DATA_TOKEN) begin
                     phase_in      = PH_DATA;
                     data_count_in = '0;
                     wait_count_in = '0;
                  end else begin
                     wait_count_in = wait_inc;
                     if (wait_inc == '0 || wait_inc >= token_limit_ff) begin
                        finish     = 1'b1;
                        fin_status = ST_TOKEN_TMO;
                     end
                  end
               end
               PH_DATA: begin
                  ctl.load_single    = 1'b1;
                  ctl.res.kind       = KIND_RX;
                  ctl.res.byte_value = rx;
                  ctl.res.status     = ST_OK;
                  if (data_count_ff == DATA_CNT_W'(BLOCK_BYTES - 1)) begin
                     ctl.res.done_res = 1'b1;
                     phase_in         = PH_IDLE;
                     data_count_in    = '0;
                  end else begin
                     data_count_in = data_count_ff + DATA_CNT_W'(1);
                  end
               end
               default: begin
               end
            endcase
            if (finish) begin
               phase_in           = PH_IDLE;
               wait_count_in      = '0;
               ctl.load_single    = 1'b1;
               ctl.res.kind       = KIND_RX;
               ctl.res.byte_value = rx;
               ctl.res.done_res   = 1'b1;
               ctl.res.status     = fin_status;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         wait_count_ff  <= '0;
         token_limit_ff <= '0;
         data_count_ff  <= '0;
      end else begin
         phase_ff       <= phase_in;
         wait_count_ff  <= wait_count_in;
         token_limit_ff <= token_limit_in;
         data_count_ff  <= data_count_in;
      end
   end

endmodule

>>> rtl/sdr_out.sv
// ----------------------------------------------------------------------------
// sdr_out
// Response register with the command frame shifter.
// ----------------------------------------------------------------------------
module sdr_out (
   input  logic                       clock,
   input  logic                       reset,
   input  sdr_pkg::ctl_type           ctl,
   input  logic [31:0]                block_address,
   input  logic [sdr_pkg::CRC_W-1:0]  crc_byte,
   output logic                       out_free,
   sdr_rsp_if.source                  rsp
);
   import sdr_pkg::*;

   localparam int SHIFT_W = 40;

   logic [FRAME_CNT_W-1:0] cnt_ff, cnt_in;
   res_type                res_ff, res_in;
   logic [SHIFT_W-1:0]     shift_ff, shift_in;
   logic                   pop;

   assign rsp.valid      = (cnt_ff != '0);
   assign rsp.kind       = res_ff.kind;
   assign rsp.byte_value = res_ff.byte_value;
   assign rsp.done_res   = res_ff.done_res;
   assign rsp.status     = res_ff.status;

   assign pop      = rsp.valid && rsp.ready;
   assign out_free = (cnt_ff == '0) || (cnt_ff == FRAME_CNT_W'(1) && rsp.ready);

   always_comb begin
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      shift_in = shift_ff;
      if (ctl.load_frame) begin
         cnt_in            = FRAME_CNT_W'(FRAME_BYTES);
         res_in.kind       = KIND_TX;
         res_in.byte_value = CMD17_BYTE;
         res_in.done_res   = 1'b0;
         res_in.status     = ST_OK;
         shift_in          = {block_address, crc_byte, 1'b1};
      end else if (ctl.load_single) begin
         cnt_in = FRAME_CNT_W'(1);
         res_in = ctl.res;
      end else if (pop) begin
         cnt_in = cnt_ff - FRAME_CNT_W'(1);
         if (cnt_ff > FRAME_CNT_W'(1)) begin
            res_in.kind       = KIND_TX;
            res_in.byte_value = shift_ff[SHIFT_W-1 -: 8];
            res_in.done_res   = (cnt_ff == FRAME_CNT_W'(2));
            res_in.status     = ST_OK;
            shift_in          = {shift_ff[SHIFT_W-9:0], 8'h00};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      shift_ff <= shift_in;
   end

endmodule

>>> rtl/sd_spi_single_block_read.sv
// ----------------------------------------------------------------------------
// sd_spi_single_block_read
// Host side of an SD card single-block read (command 17) in SPI mode.
//
//   channel  direction  contents
//   req      in         start (address, token limit) or received byte
//   rsp      out        command byte to send or data byte read, end status
//   csr      in         crc_byte (index 0), r1_wait_limit (index 1)
//
// a received-byte transaction is taken every cycle while rsp drains
// a start transaction yields six command bytes in turn; req is held
// off until the last one is leaving the response register
// synchronous reset: idle, crc_byte 0, r1_wait_limit 16
// rsp stalls hold the response register and back-pressure req
// ----------------------------------------------------------------------------
module sd_spi_single_block_read (
   input  logic                              clock,
   input  logic                              reset,
   sdr_req_if.sink                           req,
   sdr_rsp_if.source                         rsp,
   input  logic                              csr_write,
   input  logic [sdr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sdr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sdr_pkg::*;

   logic [CRC_W-1:0]  crc_ff;
   logic [WAIT_W-1:0] r1_limit_ff;
   ctl_type           ctl;
   logic              out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= '0;
         r1_limit_ff <= R1_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_CRC_BYTE:      crc_ff      <= csr_wdata[CRC_W-1:0];
            CSR_R1_WAIT_LIMIT: r1_limit_ff <= csr_wdata[WAIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   sdr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .out_free      (out_free),
      .r1_wait_limit (r1_limit_ff),
      .ctl           (ctl)
   );

   sdr_out u_out (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .block_address (req.block_address),
      .crc_byte      (crc_ff),
      .out_free      (out_free),
      .rsp           (rsp)
   );

endmodule

>>> tb/sd_spi_single_block_read_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sd_spi_single_block_read_test
// Self-checking bench for the SPI-mode single-block read host. Read frames
// and card bytes go in on req; a built-in copy of the read sequencing works
// out the command bytes, data bytes and end status each transaction owes,
// and every rsp transaction is checked against the oldest owed one. Runs a
// short directed set, then random reads under several idle/stall mixes.
// ----------------------------------------------------------------------------
module sd_spi_single_block_read_test;
   import sdr_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 8;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_R1    = 2'd1,
      PH_TOKEN = 2'd2,
      PH_DATA  = 2'd3
   } read_phase_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] block_address;
      logic [15:0] token_wait_limit;
      logic [7:0]  received_byte;
   } card_req_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sdr_req_if req_if ();
   sdr_rsp_if rsp_if ();

   sd_spi_single_block_read dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // host items waiting to be driven, results the block still owes
   card_req_type host_items[$];
   res_type      owed_results[$];

   // read sequencing state as the block should hold it
   read_phase_type   rd_phase;
   logic [15:0]      wait_cnt;
   logic [15:0]      token_lim;
   logic [9:0]       data_cnt;
   logic [CRC_W-1:0] crc_cfg;
   logic [15:0]      r1_limit_cfg;

   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_request;
   int  hold_left;
   logic req_taken;
   int  idle_cycles;
   int  mismatches;
   int  req_count;
   int  rsp_count;
   int  items_added;
   int  full_blocks;
   int  end_count[4];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic owe(input logic kind, input logic [7:0] value, input logic done,
                      input status_type st);
      res_type r;
      r.kind       = kind;
      r.byte_value = value;
      r.done_res   = done;
      r.status     = st;
      owed_results.push_back(r);
   endtask

   task automatic end_read(input logic [7:0] value, input status_type st);
      owe(KIND_RX, value, 1'b1, st);
      end_count[st]++;
      rd_phase = PH_IDLE;
      wait_cnt = '0;
   endtask

   task automatic advance_read(input card_req_type it);
      logic [15:0] lim;
      logic [7:0]  b;
      b = it.received_byte;
      if (it.operation == OP_START) begin
         owe(KIND_TX, CMD17_BYTE, 1'b0, ST_OK);
         owe(KIND_TX, it.block_address[31:24], 1'b0, ST_OK);
         owe(KIND_TX, it.block_address[23:16], 1'b0, ST_OK);
         owe(KIND_TX, it.block_address[15:8], 1'b0, ST_OK);
         owe(KIND_TX, it.block_address[7:0], 1'b0, ST_OK);
         owe(KIND_TX, {crc_cfg, 1'b1}, 1'b1, ST_OK);
         rd_phase  = PH_R1;
         wait_cnt  = '0;
         token_lim = it.token_wait_limit;
         data_cnt  = '0;
      end else begin
         case (rd_phase)
            PH_R1: begin
               if (!b[7]) begin
                  if (b[7:1] != 7'd0) end_read(b, ST_R1_ERR);
                  else if (token_lim == 16'd0) end_read(b, ST_TOKEN_TMO);
                  else begin
                     rd_phase = PH_TOKEN;
                     wait_cnt = '0;
                  end
               end else begin
                  lim      = (r1_limit_cfg == 16'd0) ? 16'd1 : r1_limit_cfg;
                  wait_cnt = wait_cnt + 16'd1;
                  if (wait_cnt == 16'd0 || wait_cnt >= lim) end_read(b, ST_R1_ERR);
               end
            end
            PH_TOKEN: begin
               if (b[7:5] == 3'd0) end_read(b, ST_TOKEN_ERR);
               else if (b == DATA_TOKEN) begin
                  rd_phase = PH_DATA;
                  data_cnt = '0;
                  wait_cnt = '0;
               end else begin
                  wait_cnt = wait_cnt + 16'd1;
                  if (wait_cnt == 16'd0 || wait_cnt >= token_lim) end_read(b, ST_TOKEN_TMO);
               end
            end
            PH_DATA: begin
               if (int'(data_cnt) + 1 >= BLOCK_BYTES) begin
                  owe(KIND_RX, b, 1'b1, ST_OK);
                  end_count[ST_OK]++;
                  full_blocks++;
                  rd_phase = PH_IDLE;
                  data_cnt = '0;
               end else begin
                  owe(KIND_RX, b, 1'b0, ST_OK);
                  data_cnt = data_cnt + 10'd1;
               end
            end
            default: ;
         endcase
      end
   endtask

   // driver
   always @(negedge clock) begin
      card_req_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (host_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = host_items.pop_front();
            req_if.valid            <= 1'b1;
            req_if.operation        <= nxt.operation;
            req_if.block_address    <= nxt.block_address;
            req_if.token_wait_limit <= nxt.token_wait_limit;
            req_if.received_byte    <= nxt.received_byte;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver readiness
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      card_req_type it;
      res_type      exp_r;
      logic         req_fire;
      logic         rsp_fire;
      req_fire = !reset && req_if.valid && req_if.ready;
      rsp_fire = !reset && rsp_if.valid && rsp_if.ready;
      req_taken <= req_fire;
      if (req_fire) begin
         it.operation        = req_if.operation;
         it.block_address    = req_if.block_address;
         it.token_wait_limit = req_if.token_wait_limit;
         it.received_byte    = req_if.received_byte;
         advance_read(it);
         req_count++;
      end
      if (rsp_fire) begin
         rsp_count++;
         if (owed_results.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result: kind %0d byte %02h done %0d status %0d",
                        rsp_if.kind, rsp_if.byte_value, rsp_if.done_res, rsp_if.status);
            mismatches++;
         end else begin
            exp_r = owed_results.pop_front();
            if (rsp_if.kind !== exp_r.kind || rsp_if.byte_value !== exp_r.byte_value ||
                rsp_if.done_res !== exp_r.done_res || rsp_if.status !== exp_r.status) begin
               if (mismatches < 10) begin
                  $display("mismatch at %0t: expected kind %0d byte %02h done %0d status %0d",
                           $realtime, exp_r.kind, exp_r.byte_value, exp_r.done_res,
                           exp_r.status);
                  $display("   actual kind %0d byte %02h done %0d status %0d",
                           rsp_if.kind, rsp_if.byte_value, rsp_if.done_res,
                           rsp_if.status);
               end
               mismatches++;
            end
         end
      end
      if (reset || req_fire || rsp_fire) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results owed",
                     idle_cycles, owed_results.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic queue_start(input logic [31:0] addr, input logic [15:0] tlim);
      card_req_type it;
      it.operation        = OP_START;
      it.block_address    = addr;
      it.token_wait_limit = tlim;
      it.received_byte    = 8'($urandom);
      host_items.push_back(it);
      items_added++;
   endtask

   task automatic queue_byte(input logic [7:0] b);
      card_req_type it;
      it.operation        = OP_BYTE;
      it.block_address    = $urandom;
      it.token_wait_limit = 16'($urandom);
      it.received_byte    = b;
      host_items.push_back(it);
      items_added++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_CRC_BYTE) crc_cfg = value[CRC_W-1:0];
      else r1_limit_cfg = value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (host_items.size() != 0 || req_if.valid || owed_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // a well-formed read with random content, cut short or broken now and then
   task automatic queue_read(input bit full_block);
      int unsigned r1_lim;
      int unsigned busy;
      int unsigned tlim;
      int unsigned waits;
      int unsigned count;
      logic [7:0]  b;
      case ($urandom_range(0, 9))
         0: tlim = 0;
         1: tlim = 16'hFFFF;
         2: tlim = $urandom_range(0, 16'hFFFF);
         default: tlim = $urandom_range(1, 6);
      endcase
      if (full_block && tlim == 0) tlim = 1;
      queue_start($urandom, tlim[15:0]);
      r1_lim = (r1_limit_cfg == 16'd0) ? 1 : r1_limit_cfg;
      busy = $urandom_range(0, (r1_lim > 5) ? 4 : r1_lim - 1);
      if (!full_block && r1_lim <= 8 && $urandom_range(0, 9) == 0) busy = r1_lim;
      repeat (busy) queue_byte(8'h80 | 8'($urandom));
      if (busy >= r1_lim) return;
      if (!full_block && $urandom_range(0, 4) == 0) begin
         queue_byte(8'($urandom_range(2, 127)));
         return;
      end
      queue_byte({7'd0, 1'($urandom)});
      if (tlim == 0) return;
      waits = (tlim > 1) ? $urandom_range(0, (tlim > 5) ? 4 : tlim - 1) : 0;
      if (!full_block && tlim <= 6 && $urandom_range(0, 9) == 0) waits = tlim;
      repeat (waits) begin
         b = 8'($urandom);
         if (b[7:5] == 3'd0) b[7] = 1'b1;
         if (b == DATA_TOKEN) b = 8'hFF;
         queue_byte(b);
      end
      if (waits >= tlim) return;
      if (!full_block && $urandom_range(0, 9) == 0) begin
         queue_byte(8'($urandom_range(0, 31)));
         return;
      end
      queue_byte(DATA_TOKEN);
      count = full_block ? BLOCK_BYTES : $urandom_range(0, 24);
      repeat (count) queue_byte(8'($urandom));
      if (full_block) repeat (2) queue_byte(8'($urandom));
   endtask

   task automatic queue_noise();
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(0, 4) == 0) queue_start($urandom, 16'($urandom));
         else queue_byte(8'($urandom));
      end
   endtask

   initial begin
      int idle_mix[4];
      int stall_mix[4];
      int mark;
      idle_mix  = '{0, 82, 0, 28};
      stall_mix = '{0, 0, 82, 28};
      reset                   = 1'b1;
      csr_write               = 1'b0;
      csr_index               = CSR_CRC_BYTE;
      csr_wdata               = '0;
      req_if.valid            = 1'b0;
      req_if.operation        = OP_BYTE;
      req_if.block_address    = '0;
      req_if.token_wait_limit = '0;
      req_if.received_byte    = '0;
      rsp_if.ready            = 1'b0;
      req_taken               = 1'b0;
      hold_request            = 1'b0;
      hold_left               = 0;
      send_idle_pct           = 0;
      recv_stall_pct          = 0;
      idle_cycles             = 0;
      mismatches              = 0;
      req_count               = 0;
      rsp_count               = 0;
      items_added             = 0;
      full_blocks             = 0;
      end_count               = '{0, 0, 0, 0};
      rd_phase                = PH_IDLE;
      wait_cnt                = '0;
      token_lim               = '0;
      data_cnt                = '0;
      crc_cfg                 = '0;
      r1_limit_cfg            = R1_LIMIT_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // bytes while idle are dropped; zero token limit ends on the r1 byte
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_start(32'hFFFF_FFFF, 16'd0);
      queue_byte(8'h00);
      wait_drained();

      write_csr(CSR_CRC_BYTE, 16'h007F);
      write_csr(CSR_R1_WAIT_LIMIT, 16'd0);
      // r1 with a bit other than idle
      queue_start(32'h0000_0000, 16'hFFFF);
      queue_byte(8'h04);
      // zero r1 limit: first busy byte times out
      queue_start(32'h1234_5678, 16'hFFFF);
      queue_byte(8'hFF);
      // token wait timeout
      queue_start($urandom, 16'd1);
      queue_byte(8'h01);
      queue_byte(8'h7F);
      // error token after a plain wait byte
      queue_start($urandom, 16'd16);
      queue_byte(8'h00);
      queue_byte(8'hE5);
      queue_byte(8'h1F);
      // restart in the middle of the data
      queue_start($urandom, 16'hFFFF);
      queue_byte(8'h01);
      queue_byte(DATA_TOKEN);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_start($urandom, 16'd3);
      queue_byte(8'h80);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_mix[ph];
         recv_stall_pct = stall_mix[ph];
         case (ph)
            0: write_csr(CSR_CRC_BYTE, 16'h0000);
            1: write_csr(CSR_CRC_BYTE, 16'h007F);
            default: write_csr(CSR_CRC_BYTE, 16'($urandom_range(0, 127)));
         endcase
         case (ph)
            0: write_csr(CSR_R1_WAIT_LIMIT, 16'd1);
            1: write_csr(CSR_R1_WAIT_LIMIT, 16'hFFFF);
            2: write_csr(CSR_R1_WAIT_LIMIT, R1_LIMIT_RESET);
            default: write_csr(CSR_R1_WAIT_LIMIT, 16'($urandom_range(2, 10)));
         endcase
         if (ph == 0) begin
            @(posedge clock);
            hold_request = 1'b1;
         end
         mark = items_added;
         while (items_added - mark < 44) begin
            if ($urandom_range(0, 3) == 0) queue_noise();
            else queue_read(1'b0);
         end
         wait_drained();
      end

      $display("covered %0d request and %0d result transactions, %0d full blocks read",
               req_count, rsp_count, full_blocks);
      $display("read endings: ok %0d, r1 error %0d, error token %0d, token timeout %0d",
               end_count[ST_OK], end_count[ST_R1_ERR], end_count[ST_TOKEN_ERR],
               end_count[ST_TOKEN_TMO]);
      if (mismatches == 0 && owed_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results still owed", mismatches, owed_results.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/sdr_pkg.sv
rtl/sdr_req_if.sv
rtl/sdr_rsp_if.sv
rtl/sdr_ctrl.sv
rtl/sdr_out.sv
rtl/sd_spi_single_block_read.sv
tb/sd_spi_single_block_read_test.sv
